@@ design/median_pt1000_temperature_top_macros.svh @@
// assertion macros for the median pt1000 block
`ifndef MEDIAN_PT1000_TEMPERATURE_TOP_MACROS_SVH
`define MEDIAN_PT1000_TEMPERATURE_TOP_MACROS_SVH

// property must hold at every clock edge outside reset
`define MPT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after antecedent
`define MPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/mpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mpt_pkg
// Shared types and constants for the median pt1000 temperature block.
// ----------------------------------------------------------------------------
package mpt_pkg;
	localparam int SampleCountDefault = 16;
	localparam int CodeW = 12;
	localparam int TempW = 16;

	// median handed from the front to the back through the queue
	typedef struct packed {
		logic [CodeW-1:0] median;
	} med_item_t;

	// result item of the back end
	typedef struct packed {
		logic signed [TempW-1:0] temperature_mc;
		logic [CodeW-1:0]        median_code;
		logic                    clipped;
	} res_item_t;

	// conversion constants: t = NumK*(NumA*m - NumB) / (DenK*(DenA - DenB*m))
	localparam longint NumK = 64'd20000000;
	localparam longint NumA = 64'd880000;
	localparam longint NumB = 64'd830979513;
	localparam longint DenK = 64'd77;
	localparam longint DenA = 64'd9233452683;
	localparam longint DenB = 64'd80000;
endpackage

@@ design/mpt_front.sv @@
// ----------------------------------------------------------------------------
// mpt_front
// Insertion sort of samples into a store, one shift step per cycle; emits
// the batch median when the batch is complete.
// ----------------------------------------------------------------------------
module mpt_front #(
	parameter int SAMPLE_COUNT = mpt_pkg::SampleCountDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [mpt_pkg::CodeW-1:0] in_sample,
	output logic                     med_valid,
	input  logic                     med_ready,
	output mpt_pkg::med_item_t       med_item
);
	import mpt_pkg::*;

	localparam int IdxW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam int CntW = $clog2(SAMPLE_COUNT + 1);
	localparam logic [1:0] StIdle = 2'd0, StIns = 2'd1, StMedA = 2'd2, StOut = 2'd3;
	localparam logic [IdxW-1:0] MidLo = IdxW'((SAMPLE_COUNT - 1) / 2);
	localparam logic [IdxW-1:0] MidHi = IdxW'(SAMPLE_COUNT / 2);
	localparam bit IsEven = (SAMPLE_COUNT % 2) == 0;

	logic [CodeW-1:0] store_q [SAMPLE_COUNT];
	logic [1:0]       state_q;
	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  pos_q;
	logic [CodeW-1:0] new_q;
	logic [CodeW-1:0] rd_q;
	logic [CodeW-1:0] lo_q;
	logic [CodeW:0]   sum;
	logic [IdxW-1:0]  prev_idx;

	assign in_ready  = (state_q == StIdle);
	assign med_valid = (state_q == StOut);
	assign prev_idx  = IdxW'(pos_q - CntW'(1));
	assign sum       = {1'b0, lo_q} + {1'b0, rd_q};

	// store memory: shift up and insert at the current position
	always_ff @(posedge clk) begin
		if (state_q == StIns) begin
			if (pos_q != '0 && new_q < rd_q) begin
				store_q[IdxW'(pos_q)] <= rd_q;
			end else begin
				store_q[IdxW'(pos_q)] <= new_q;
			end
		end
	end

	// registered read of the entry below the insertion point, or the middles;
	// held while the median item waits
	always_ff @(posedge clk) begin
		if (state_q == StIdle) begin
			rd_q <= store_q[IdxW'(count_q - CntW'(1))];
		end else if (state_q == StIns && pos_q != '0 && new_q < rd_q) begin
			rd_q <= store_q[IdxW'(prev_idx - IdxW'(1))];
		end else if (state_q == StIns) begin
			// the entry written on this edge is not yet in the store
			rd_q <= (IdxW'(pos_q) == MidLo) ? new_q : store_q[MidLo];
		end else if (state_q == StMedA) begin
			rd_q <= store_q[MidHi];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (in_valid) begin
						state_q <= StIns;
						pos_q   <= count_q;
					end
				end
				StIns: begin
					if (pos_q != '0 && new_q < rd_q) begin
						pos_q <= pos_q - CntW'(1);
					end else if (count_q + CntW'(1) == CntW'(SAMPLE_COUNT)) begin
						count_q <= '0;
						state_q <= StMedA;
					end else begin
						count_q <= count_q + CntW'(1);
						state_q <= StIdle;
					end
				end
				StMedA: state_q <= StOut;
				StOut: begin
					if (med_ready) state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// sample and low middle entry
	always_ff @(posedge clk) begin
		if (state_q == StIdle && in_valid) new_q <= in_sample;
		if (state_q == StMedA) lo_q <= rd_q;
	end

	// rd_q holds the high middle in StOut
	always_comb begin
		if (IsEven) med_item.median = sum[CodeW:1];
		else        med_item.median = rd_q;
	end
endmodule

@@ design/mpt_queue.sv @@
// ----------------------------------------------------------------------------
// mpt_queue
// Two-entry queue between the sorting front and the conversion back.
// ----------------------------------------------------------------------------
module mpt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  mpt_pkg::med_item_t wr_item,
	output logic               rd_valid,
	input  logic               rd_ready,
	output mpt_pkg::med_item_t rd_item
);
	import mpt_pkg::*;

	med_item_t  mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] fill_q;
	logic       wr_en;
	logic       rd_en;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_item  = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_item;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			fill_q <= fill_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule

@@ design/mpt_back.sv @@
// ----------------------------------------------------------------------------
// mpt_back
// Converts a median code to millicelsius: two multiply steps, then a
// restoring divider with one quotient bit per cycle, then saturation.
// ----------------------------------------------------------------------------
module mpt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               med_valid,
	output logic               med_ready,
	input  mpt_pkg::med_item_t med_item,
	output logic               out_valid,
	input  logic               out_ready,
	output mpt_pkg::res_item_t out_item
);
	import mpt_pkg::*;

	// numerator magnitude < 2^56, divisor < 2^40
	localparam int NW = 56;
	localparam int DW = 41;
	localparam logic [2:0] StIdle = 3'd0, StMul1 = 3'd1, StMul2 = 3'd2;
	localparam logic [2:0] StDiv = 3'd3, StSat = 3'd4, StOut = 3'd5;

	logic [2:0]       state_q;
	logic [CodeW-1:0] code_q;
	logic signed [32:0] a_q;
	logic [DW-1:0]    den_q;
	logic [NW-1:0]    quo_q;
	logic [DW:0]      rem_q;
	logic             neg_q;
	logic [5:0]       cnt_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      rem_sub;
	logic signed [63:0] num_full;
	logic [NW-1:0]    num_mag;
	res_item_t        res_q;
	logic [NW-1:0]    qmag;

	assign med_ready = (state_q == StIdle);
	assign out_valid = (state_q == StOut);
	assign out_item  = res_q;
	assign num_full  = 64'(a_q) * NumK;
	assign num_mag   = num_full[63] ? NW'(-num_full) : NW'(num_full);
	assign rem_sh    = {rem_q[DW-1:0], quo_q[NW-1]};
	assign rem_sub   = rem_sh - {1'b0, den_q};
	assign qmag      = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				StIdle: if (med_valid) state_q <= StMul1;
				StMul1: state_q <= StMul2;
				StMul2: begin
					state_q <= StDiv;
					cnt_q   <= 6'(NW - 1);
				end
				StDiv: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) state_q <= StSat;
				end
				StSat: state_q <= StOut;
				StOut: if (out_ready) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: if (med_valid) code_q <= med_item.median;
			StMul1: begin
				a_q   <= 33'(NumA * 64'(code_q) - NumB);
				den_q <= DW'(DenK * (DenA - DenB * 64'(code_q)));
			end
			StMul2: begin
				quo_q <= num_mag;
				neg_q <= num_full[63];
				rem_q <= '0;
			end
			StDiv: begin
				if (!rem_sub[DW]) begin
					rem_q <= rem_sub;
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
			end
			StSat: begin
				res_q.median_code <= code_q;
				if (!neg_q && qmag > NW'(32767)) begin
					res_q.temperature_mc <= 16'sh7FFF;
					res_q.clipped        <= 1'b1;
				end else if (neg_q && qmag > NW'(32768)) begin
					res_q.temperature_mc <= 16'sh8000;
					res_q.clipped        <= 1'b1;
				end else begin
					res_q.temperature_mc <= neg_q ? -TempW'(qmag) : TempW'(qmag);
					res_q.clipped        <= 1'b0;
				end
			end
			default: ;
		endcase
	end
endmodule

@@ design/median_pt1000_temperature_top.sv @@
// ----------------------------------------------------------------------------
// median_pt1000_temperature_top
// Median filter over a batch of ADC codes with PT1000 conversion.
// ----------------------------------------------------------------------------
// Input channel: sample (12-bit ADC code) with in_valid / in_ready.
// Output channel: temperature_mc, median_code, clipped with out_valid /
// out_ready; one result item for every SAMPLE_COUNT samples.
// In the front, each sample is taken in the idle state and then placed by
// the insertion sort, which shifts the stored entries above it (0 to
// SAMPLE_COUNT-1 of them) one at a time; the single-port store sets this.
// A completed batch then passes through a state that reads the middle entries.
// The back end converts a median by two multiply steps, the bit-serial
// divider (56 quotient bits) and saturation, and runs alongside the front.
// A two-entry queue sits between them, so a stalled receiver stops only the back
// end until the queue fills; once the front holds a median, in_ready stays low.
// Reset empties the queue and starts a new batch; the store contents are
// not cleared, as they are always rewritten before any read of them is used.
// ----------------------------------------------------------------------------
module median_pt1000_temperature_top #(
	parameter int SAMPLE_COUNT = mpt_pkg::SampleCountDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mpt_pkg::CodeW-1:0]        sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [mpt_pkg::TempW-1:0] temperature_mc,
	output logic [mpt_pkg::CodeW-1:0]        median_code,
	output logic                             clipped
);
	import mpt_pkg::*;
	`include "median_pt1000_temperature_top_macros.svh"

	logic      fq_valid, fq_ready, qb_valid, qb_ready;
	med_item_t fq_item, qb_item;
	res_item_t res;

	mpt_front #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_sample(sample),
		.med_valid(fq_valid), .med_ready(fq_ready), .med_item(fq_item)
	);

	mpt_queue u_queue (
		.clk, .arst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_item(qb_item)
	);

	mpt_back u_back (
		.clk, .arst_n, .med_valid(qb_valid), .med_ready(qb_ready), .med_item(qb_item),
		.out_valid, .out_ready, .out_item(res)
	);

	assign temperature_mc = res.temperature_mc;
	assign median_code    = res.median_code;
	assign clipped        = res.clipped;

	// checks
	`MPT_ASSERT(a_clip_bound, !out_valid || !clipped || temperature_mc == 16'sh7FFF || temperature_mc == 16'sh8000, "clipped result not at a bound")
	`MPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(median_code), "result dropped while stalled")
	`MPT_ASSERT_NEXT(a_in_take, in_valid && in_ready, !in_ready, "front took two items back to back")
endmodule

@@ test/tb_median_pt1000_temperature_top.sv @@
// ----------------------------------------------------------------------------
// tb_median_pt1000_temperature_top
// Self-checking bench for the median pt1000 temperature block.
// ----------------------------------------------------------------------------
// Samples are sent over the valid/ready input channel. A local model keeps
// the batch, takes the median once a batch is full and converts it to
// millicelsius using 64-bit integer arithmetic. Each result item coming out
// is compared field by field against the oldest predicted one. Both sides
// idle at random, and one long receiver hold-off fills the block until it
// stalls its input.
// ----------------------------------------------------------------------------
module tb_median_pt1000_temperature_top;
	import mpt_pkg::*;

	localparam int NSamp = SampleCountDefault;
	localparam int MaxMismatchShown = 10;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [CodeW-1:0]        sample;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [TempW-1:0] temperature_mc;
	logic [CodeW-1:0]        median_code;
	logic                    clipped;

	median_pt1000_temperature_top #(.SAMPLE_COUNT(NSamp)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.temperature_mc(temperature_mc),
		.median_code(median_code),
		.clipped(clipped)
	);

	// model state: the current batch, kept in arrival order, and the predicted results
	logic [CodeW-1:0] batch_codes[$];
	res_item_t        pending_temps[$];

	int  mismatches;
	int  results_seen;
	int  samples_sent;
	bit  quiet_send;
	bit  quiet_recv;
	bit  hold_recv;

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// median to millicelsius, truncated toward zero, saturated
	function automatic res_item_t convert_median(logic [CodeW-1:0] m);
		longint    num;
		longint    den;
		longint    t;
		res_item_t r;
		num = 64'sd20000000 * (64'sd880000 * longint'(m) - 64'sd830979513);
		den = 64'sd77 * (64'sd9233452683 - 64'sd80000 * longint'(m));
		t = num / den;
		r.clipped = 1'b0;
		if (t > 32767) begin
			t = 32767;
			r.clipped = 1'b1;
		end else if (t < -32768) begin
			t = -32768;
			r.clipped = 1'b1;
		end
		r.temperature_mc = t[TempW-1:0];
		r.median_code = m;
		return r;
	endfunction

	// take one accepted sample into the batch, predict a result when full
	task automatic predict_sample(logic [CodeW-1:0] s);
		logic [CodeW-1:0] srt[$];
		int unsigned      med;
		batch_codes.push_back(s);
		if (batch_codes.size() == NSamp) begin
			srt = batch_codes;
			srt.sort();
			if (NSamp % 2 == 0)
				med = (int'(srt[NSamp/2-1]) + int'(srt[NSamp/2])) / 2;
			else
				med = srt[NSamp/2];
			pending_temps.push_back(convert_median(med[CodeW-1:0]));
			batch_codes.delete();
		end
	endtask

	// send one item, with random idle cycles before it unless quiet;
	// valid stays high after acceptance until the next call or an explicit drop
	task automatic send_sample(logic [CodeW-1:0] s);
		while (!quiet_send && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_sample(s);
		samples_sent++;
	endtask

	// receiver ready, random idling, suppressed during a hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !hold_recv && (quiet_recv || $urandom_range(99) >= 30);
		end
	end

	// result checker
	always @(posedge clk) begin
		res_item_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_temps.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxMismatchShown)
					$display("unexpected result: t=%0d med=%0d clip=%0d",
						temperature_mc, median_code, clipped);
			end else begin
				exp_r = pending_temps.pop_front();
				if (temperature_mc !== exp_r.temperature_mc
						|| median_code !== exp_r.median_code
						|| clipped !== exp_r.clipped) begin
					mismatches++;
					if (mismatches <= MaxMismatchShown)
						$display("mismatch: exp t=%0d med=%0d clip=%0d, got t=%0d med=%0d clip=%0d",
							exp_r.temperature_mc, exp_r.median_code, exp_r.clipped,
							temperature_mc, median_code, clipped);
				end
			end
		end
	end

	// one batch of the same code
	task automatic send_flat_batch(logic [CodeW-1:0] c);
		repeat (NSamp) send_sample(c);
	endtask

	// extremes of the code range: the top end saturates, the rest does not
	task automatic test_extremes();
		send_flat_batch('0);
		send_flat_batch('1);
		send_flat_batch(12'd2048);
		send_flat_batch(12'd1000);
	endtask

	// even count: mean of the two middle entries, truncated; two runs of equal codes, then distinct falling codes
	task automatic test_even_median();
		for (int i = 0; i < NSamp; i++)
			send_sample((i < NSamp/2) ? 12'd1001 : 12'd1004);
		for (int i = 0; i < NSamp; i++)
			send_sample(12'(4095 - i * 200));
	endtask

	// random batches: mostly spread round a random centre, some full range
	task automatic test_random_batches(int nbatch);
		int centre;
		int spread;
		for (int b = 0; b < nbatch; b++) begin
			centre = $urandom_range(4095);
			spread = $urandom_range(3) == 0 ? 4095 : $urandom_range(200);
			for (int i = 0; i < NSamp; i++) begin
				int v;
				v = centre + $urandom_range(2 * spread) - spread;
				if ($urandom_range(7) == 0 || v < 0 || v > 4095)
					v = $urandom_range(4095);
				send_sample(12'(v));
			end
		end
	endtask

	// no idling either side
	task automatic test_back_to_back();
		quiet_send = 1'b1;
		quiet_recv = 1'b1;
		test_random_batches(6);
		quiet_send = 1'b0;
		quiet_recv = 1'b0;
	endtask

	// receiver holds off long enough for the block to stall its input
	task automatic test_receiver_holdoff();
		fork
			begin
				hold_recv = 1'b1;
				repeat (1500) @(posedge clk);
				hold_recv = 1'b0;
			end
			begin
				test_random_batches(5);
				in_valid <= 1'b0;
			end
		join
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		mismatches = 0;
		results_seen = 0;
		samples_sent = 0;
		quiet_send = 1'b0;
		quiet_recv = 1'b0;
		hold_recv = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_even_median();
		test_back_to_back();
		test_receiver_holdoff();
		test_random_batches(28);
		in_valid <= 1'b0;

		while (pending_temps.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("covered %0d samples, %0d result items incl. saturation and stall",
			samples_sent, results_seen);
		if (mismatches == 0 && pending_temps.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/mpt_pkg.sv
design/mpt_front.sv
design/mpt_queue.sv
design/mpt_back.sv
design/median_pt1000_temperature_top.sv
test/tb_median_pt1000_temperature_top.sv
